// ===== rtl/vfcm_pkg.sv =====
// Shared types, codes and face tables for the voxel face-culling mesher.
`timescale 1ns / 1ps

package vfcm_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILLER  = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    localparam logic [2:0] FACE_NX = 3'd0;
    localparam logic [2:0] FACE_PX = 3'd1;
    localparam logic [2:0] FACE_NZ = 3'd2;
    localparam logic [2:0] FACE_PZ = 3'd3;
    localparam logic [2:0] FACE_NY = 3'd4;
    localparam logic [2:0] FACE_PY = 3'd5;

    localparam logic [2:0] LAST_FACE = FACE_PY;
    localparam logic [2:0] LAST_VERT = 3'd5;

    // corner offsets per face and vertex, packed x<<2 | y<<1 | z
    localparam logic [2:0] FACE_CORNER [0:5][0:5] = '{
        '{3'd1, 3'd2, 3'd0, 3'd2, 3'd1, 3'd3},
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd1, 3'd2},
        '{3'd2, 3'd4, 3'd0, 3'd4, 3'd2, 3'd6},
        '{3'd0, 3'd4, 3'd2, 3'd6, 3'd2, 3'd4},
        '{3'd4, 3'd1, 3'd0, 3'd1, 3'd4, 3'd5},
        '{3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd5}
    };

    typedef struct packed {
        logic        operation;
        logic [3:0]  pos_x;
        logic [3:0]  pos_y;
        logic [3:0]  pos_z;
        logic [31:0] color;
    } t_in;

    typedef struct packed {
        logic [4:0] vert_x;
        logic [4:0] vert_y;
        logic [4:0] vert_z;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] face;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [31:0] blocker;
        logic [31:0] filler;
    } t_colours;

endpackage

// ===== rtl/voxel_face_culling_mesher_top.sv =====
// Top level: command sequencer around the voxel store, emitting face vertices.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+----------------------------
//  command | in        | start high, busy low   | i_cmd (t_in)
//  vertex  | out       | o_res_valid, one cycle | o_res (t_out)
//  config  | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// A write word holds busy through address setup and the store write state. A mesh word
// holds busy through address setup and seven store reads through the one read port, then
// a pass over each clear face before the last blocked face and six vertices per blocked
// face. Reset is synchronous and active low; the store is not cleared.
// Vertices leave on o_res_valid, one per cycle within a blocked face, and cannot be held off.
`timescale 1ns / 1ps

module voxel_face_culling_mesher_top
    import vfcm_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_cmd,
    output logic                  o_res_valid,
    output t_out                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int EW = $clog2(MAX_DIM + 1);
    localparam int CW = (EW > 5) ? EW : 5;
    localparam int AW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
    localparam int PW = 4 + 2 * EW;

    typedef enum logic [2:0] {S_IDLE, S_CALC, S_WRITE, S_READ, S_EMIT} t_state;

    logic [EW-1:0]   w_eff_x, w_eff_y, w_eff_z;
    logic [2*EW-1:0] w_yz;
    t_colours        w_col;

    vfcm_cfg #(
        .MAX_DIM (MAX_DIM),
        .EW      (EW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_eff_x    (w_eff_x),
        .o_eff_y    (w_eff_y),
        .o_eff_z    (w_eff_z),
        .o_yz       (w_yz),
        .o_colours  (w_col)
    );

    t_state        r_state;
    logic          r_op;
    logic [3:0]    r_x, r_y, r_z;
    logic [31:0]   r_color;
    logic [AW-1:0] r_base;
    logic [6:0]    r_inb;
    logic [2:0]    r_k;
    logic [31:0]   r_vox;
    logic [5:0]    r_solid;
    logic [2:0]    r_f, r_v;
    logic          r_res_valid;
    t_out          r_res;

    // bounds of the voxel and its six neighbours
    logic [CW-1:0] w_xc, w_yc, w_zc, w_ex, w_ey, w_ez;
    logic          w_ix, w_iy, w_iz, w_xm, w_xp, w_ym, w_yp, w_zm, w_zp;
    logic [6:0]    w_inb;
    logic [PW-1:0] w_xyz, w_yzo;
    logic [AW-1:0] w_base;

    always_comb begin
        w_xc = CW'(r_x);
        w_yc = CW'(r_y);
        w_zc = CW'(r_z);
        w_ex = CW'(w_eff_x);
        w_ey = CW'(w_eff_y);
        w_ez = CW'(w_eff_z);
        w_ix = w_xc < w_ex;
        w_iy = w_yc < w_ey;
        w_iz = w_zc < w_ez;
        w_xm = (r_x != 4'd0) && ((w_xc - CW'(1)) < w_ex);
        w_xp = (w_xc + CW'(1)) < w_ex;
        w_ym = (r_y != 4'd0) && ((w_yc - CW'(1)) < w_ey);
        w_yp = (w_yc + CW'(1)) < w_ey;
        w_zm = (r_z != 4'd0) && ((w_zc - CW'(1)) < w_ez);
        w_zp = (w_zc + CW'(1)) < w_ez;
        w_inb[0] = w_ix && w_iy && w_iz;
        w_inb[1] = w_xm && w_iy && w_iz;
        w_inb[2] = w_xp && w_iy && w_iz;
        w_inb[3] = w_ix && w_iy && w_zm;
        w_inb[4] = w_ix && w_iy && w_zp;
        w_inb[5] = w_ix && w_ym && w_iz;
        w_inb[6] = w_ix && w_yp && w_iz;
        w_xyz  = PW'(r_x) * PW'(w_yz);
        w_yzo  = PW'(r_y) * PW'(w_eff_z);
        w_base = AW'(w_xyz) + AW'(w_yzo) + AW'(r_z);
    end

    // read address per step: centre, then faces in emission order
    logic [AW-1:0] w_raddr;
    logic          w_re, w_we;
    logic [31:0]   w_rdata, w_val;
    logic [2:0]    w_j;

    always_comb begin
        case (r_k)
            3'd0:    w_raddr = r_base;
            3'd1:    w_raddr = r_base - AW'(w_yz);
            3'd2:    w_raddr = r_base + AW'(w_yz);
            3'd3:    w_raddr = r_base - AW'(1);
            3'd4:    w_raddr = r_base + AW'(1);
            3'd5:    w_raddr = r_base - AW'(w_eff_z);
            3'd6:    w_raddr = r_base + AW'(w_eff_z);
            default: w_raddr = r_base;
        endcase
    end

    assign w_re = (r_state == S_READ) && (r_k != 3'd7);
    assign w_we = (r_state == S_WRITE) && r_inb[0];

    vfcm_store #(
        .AW (AW),
        .DW (32)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_base),
        .i_wdata (r_color),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_j   = r_k - 3'd1;
    assign w_val = r_inb[w_j] ? w_rdata : w_col.blocker;

    logic w_visible, w_clear, w_more, w_face_on;
    logic [5:0] w_above;
    logic [2:0] w_corner;

    assign w_visible = (r_vox[7:0] != 8'd0) && (r_vox != w_col.filler)
                       && (r_vox != w_col.blocker);
    assign w_clear   = (w_val[7:0] != 8'd0) && (w_val != w_col.blocker);
    assign w_above   = r_solid >> r_f;
    assign w_more    = |w_above[5:1];
    assign w_face_on = r_solid[r_f];
    assign w_corner  = FACE_CORNER[r_f][r_v];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_k         <= 3'd0;
            r_f         <= 3'd0;
            r_v         <= 3'd0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_cmd.operation;
                        r_x     <= i_cmd.pos_x;
                        r_y     <= i_cmd.pos_y;
                        r_z     <= i_cmd.pos_z;
                        r_color <= i_cmd.color;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_base  <= w_base;
                    r_inb   <= w_inb;
                    r_k     <= 3'd0;
                    r_state <= (r_op == OP_WRITE) ? S_WRITE : S_READ;
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    if (r_k != 3'd0) begin
                        if (w_j == 3'd0) begin
                            r_vox <= w_val;
                        end else begin
                            r_solid[w_j - 3'd1] <= !w_clear;
                        end
                    end
                    if (r_k == 3'd7) begin
                        r_f     <= FACE_NX;
                        r_v     <= 3'd0;
                        // +y face result lands this cycle
                        r_state <= (w_visible && ({!w_clear, r_solid[4:0]} != 6'd0)) ?
                                   S_EMIT : S_IDLE;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_EMIT: begin
                    if (w_face_on) begin
                        r_res_valid  <= 1'b1;
                        r_res.vert_x <= 5'(r_x) + 5'(r_f == FACE_PX) + 5'(w_corner[2]);
                        r_res.vert_y <= 5'(r_y) + 5'(r_f == FACE_PY) + 5'(w_corner[1]);
                        r_res.vert_z <= 5'(r_z) + 5'(r_f == FACE_PZ) + 5'(w_corner[0]);
                        r_res.red    <= r_vox[31:24];
                        r_res.green  <= r_vox[23:16];
                        r_res.blue   <= r_vox[15:8];
                        r_res.face   <= r_f;
                        r_res.last   <= (r_v == LAST_VERT) && !w_more;
                    end
                    if (w_face_on && (r_v != LAST_VERT)) begin
                        r_v <= r_v + 3'd1;
                    end else begin
                        r_v <= 3'd0;
                        if ((r_f == LAST_FACE) || !w_more) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_f <= r_f + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_state == S_EMIT))
        else $error("vertex strobe outside face emission");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("vertex strobe straight after last vertex");

    a_write_only_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_op == OP_WRITE) && !w_re)
        else $error("store written by a mesh command");

endmodule

// ===== rtl/vfcm_store.sv =====
// Voxel colour store: single-port-write, registered-read synchronous RAM.
`timescale 1ns / 1ps

module vfcm_store #(
    parameter int AW = 12,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(2**AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vfcm_cfg.sv =====
// Configuration registers with clamped chunk sizes and the y*z stride.
`timescale 1ns / 1ps

module vfcm_cfg
    import vfcm_pkg::*;
#(
    parameter int MAX_DIM = 16,
    parameter int EW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [EW-1:0]         o_eff_x,
    output logic [EW-1:0]         o_eff_y,
    output logic [EW-1:0]         o_eff_z,
    output logic [2*EW-1:0]       o_yz,
    output t_colours              o_colours
);

    function automatic logic [EW-1:0] eff(input logic [4:0] s);
        logic [EW-1:0] e;
        if (s == 5'd0) begin
            e = EW'(1);
        end else if (int'(s) > MAX_DIM) begin
            e = EW'(MAX_DIM);
        end else begin
            e = EW'(s);
        end
        return e;
    endfunction

    logic [4:0]      r_size_x, r_size_y, r_size_z;
    logic [4:0]      n_size_x, n_size_y, n_size_z;
    logic [2*EW-1:0] r_yz, n_yz;
    t_colours        r_col, n_col;

    always_comb begin
        n_size_x = r_size_x;
        n_size_y = r_size_y;
        n_size_z = r_size_z;
        n_yz     = r_yz;
        n_col    = r_col;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE_X: begin
                    n_size_x = i_cfg_data[4:0];
                end
                REG_SIZE_Y: begin
                    n_size_y = i_cfg_data[4:0];
                    n_yz = (2*EW)'(eff(i_cfg_data[4:0])) * (2*EW)'(eff(r_size_z));
                end
                REG_SIZE_Z: begin
                    n_size_z = i_cfg_data[4:0];
                    n_yz = (2*EW)'(eff(r_size_y)) * (2*EW)'(eff(i_cfg_data[4:0]));
                end
                REG_BLOCKER: begin
                    n_col.blocker = i_cfg_data;
                end
                REG_FILLER: begin
                    n_col.filler = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 5'd16;
            r_size_y <= 5'd16;
            r_size_z <= 5'd16;
            r_yz     <= (2*EW)'(eff(5'd16)) * (2*EW)'(eff(5'd16));
            r_col    <= '0;
        end else begin
            r_size_x <= n_size_x;
            r_size_y <= n_size_y;
            r_size_z <= n_size_z;
            r_yz     <= n_yz;
            r_col    <= n_col;
        end
    end

    assign o_eff_x   = eff(r_size_x);
    assign o_eff_y   = eff(r_size_y);
    assign o_eff_z   = eff(r_size_z);
    assign o_yz      = r_yz;
    assign o_colours = r_col;

endmodule
